FILE: rtl/ptpg_pkg.sv
`timescale 1ns / 1ps
package ptpg_pkg;

    localparam int TILE_SIZE_DEF  = 64;
    localparam int KIND_COUNT_DEF = 10;
    localparam int KIND_TABLE_LEN = 10;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_S = 32'd1274126177;
    localparam logic [31:0] HASH_MUL_M = 32'd2246822519;

    typedef struct packed {
        logic [31:0] seed1;
        logic [4:0]  amp1;
        logic [3:0]  off1;
        logic [31:0] seed2;
        logic [2:0]  scale2;
        logic [3:0]  amp2;
        logic [2:0]  off2;
        logic [31:0] seeds;
        logic [2:0]  scales;
        logic [31:0] thr;
        logic [7:0]  hit_r;
        logic [7:0]  hit_g;
        logic [7:0]  hit_b;
        logic [7:0]  miss_r;
        logic [7:0]  miss_g;
        logic [7:0]  miss_b;
    } kind_desc_t;

    function automatic kind_desc_t kind_lookup(input logic [3:0] k);
        kind_desc_t d;
        case (k)
            4'd1: d = '{32'd211, 5'd22, 4'd11, 32'd0, 3'd1, 4'd0, 3'd0, 32'd212, 3'd4,
                        32'd2791728741, 8'd45, 8'd75, 8'd40, 8'd70, 8'd90, 8'd55};
            4'd2: d = '{32'd221, 5'd12, 4'd6, 32'd0, 3'd1, 4'd0, 3'd0, 32'd222, 3'd5,
                        32'd3951369911, 8'd245, 8'd243, 8'd247, 8'd228, 8'd226, 8'd230};
            4'd3: d = '{32'd231, 5'd25, 4'd12, 32'd0, 3'd1, 4'd0, 3'd0, 32'd232, 3'd2,
                        32'd2147483647, 8'd130, 8'd115, 8'd78, 8'd105, 8'd120, 8'd70};
            4'd4: d = '{32'd99, 5'd30, 4'd15, 32'd0, 3'd1, 4'd0, 3'd0, 32'd100, 3'd5,
                        32'd3006477106, 8'd60, 8'd110, 8'd40, 8'd75, 8'd125, 8'd50};
            4'd5: d = '{32'd241, 5'd20, 4'd10, 32'd0, 3'd1, 4'd0, 3'd0, 32'd242, 3'd3,
                        32'd2362232012, 8'd68, 8'd72, 8'd45, 8'd55, 8'd80, 8'd38};
            4'd6: d = '{32'd251, 5'd22, 4'd11, 32'd252, 3'd2, 4'd10, 3'd5, 32'd0, 3'd1,
                        32'hFFFFFFFF, 8'd195, 8'd175, 8'd130, 8'd195, 8'd175, 8'd130};
            4'd7: d = '{32'd261, 5'd25, 4'd12, 32'd0, 3'd1, 4'd0, 3'd0, 32'd262, 3'd4,
                        32'd3006477106, 8'd140, 8'd128, 8'd75, 8'd160, 8'd145, 8'd88};
            4'd8: d = '{32'd271, 5'd28, 4'd14, 32'd0, 3'd1, 4'd0, 3'd0, 32'd272, 3'd3,
                        32'd2362232012, 8'd30, 8'd105, 8'd28, 8'd55, 8'd130, 8'd45};
            4'd9: d = '{32'd281, 5'd22, 4'd11, 32'd282, 3'd4, 4'd14, 3'd7, 32'd283, 3'd2,
                        32'd2362232012, 8'd158, 8'd140, 8'd104, 8'd178, 8'd158, 8'd118};
            default: d = '{32'd201, 5'd25, 4'd12, 32'd0, 3'd1, 4'd0, 3'd0, 32'd202, 3'd3,
                        32'd2576980377, 8'd88, 8'd95, 8'd72, 8'd115, 8'd112, 8'd98};
        endcase
        return d;
    endfunction

    // signed channel value with 8 fractional bits to a byte
    function automatic logic [7:0] to_byte(input logic signed [17:0] v);
        logic [17:0] r;
        r = 18'(v + 18'sd128);
        if (v < 0)
            return 8'd0;
        else if (v > 18'sd65280)
            return 8'd255;
        else
            return r[15:8];
    endfunction

endpackage

FILE: rtl/procedural_tile_pixel_generator_top.sv
`timescale 1ns / 1ps
// channel  | direction | handshake     | payload
// in       | input     | valid / ready | col, line, kind
// out      | output    | out_valid / out_ready | red, green, blue
//
// one item per cycle while the output is not stalled; five register stages,
// stage 1 decodes the kind and scales coordinates, stage 2 multiplies the three
// hash terms, stage 3 xors and does the mix multiply, stage 4 folds, scales
// by amplitude and compares the selector, stage 5 sums, clamps and rounds into
// the output register; reset clears only the valid bits; the whole pipe advances
// when the output register is empty or being taken, so a stall holds every stage
// in place
module procedural_tile_pixel_generator_top
#(
    parameter int TILE_SIZE  = ptpg_pkg::TILE_SIZE_DEF,
    parameter int KIND_COUNT = ptpg_pkg::KIND_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic [5:0] col,
    input  logic [5:0] line,
    input  logic [3:0] kind,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    import ptpg_pkg::*;

    localparam int CW = $clog2(TILE_SIZE) < 6 ? $clog2(TILE_SIZE) : 6;
    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    // one stall for the whole pipe
    assign adv   = !vld_reg[NSTG-1] || out_ready;
    assign ready = adv;
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], valid};
    end

    // stage 1: decode and scale coordinates
    kind_desc_t  d1_reg;
    logic [31:0] x1_reg, y1_reg, x2_reg, y2_reg, xs_reg, ys_reg;
    logic [31:0] xw, yw;
    kind_desc_t  dn;

    always_comb
    begin
        xw = 32'(col[CW-1:0]);
        yw = 32'(line[CW-1:0]);
        if (32'(kind) >= 32'(KIND_COUNT) || 32'(kind) >= 32'(KIND_TABLE_LEN))
            dn = kind_lookup(4'd0);
        else
            dn = kind_lookup(kind);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg <= dn;
            x1_reg <= xw;
            y1_reg <= yw;
            x2_reg <= 32'(xw * 32'(dn.scale2));
            y2_reg <= 32'(yw * 32'(dn.scale2));
            xs_reg <= 32'(xw * 32'(dn.scales));
            ys_reg <= 32'(yw * 32'(dn.scales));
        end
    end

    // stage 2: hash term products
    kind_desc_t  d2_reg;
    logic [31:0] t1_reg [3];
    logic [31:0] t2_reg [3];
    logic [31:0] t3_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg    <= d1_reg;
            t1_reg[0] <= 32'(x1_reg * HASH_MUL_X);
            t1_reg[1] <= 32'(y1_reg * HASH_MUL_Y);
            t1_reg[2] <= 32'(d1_reg.seed1 * HASH_MUL_S);
            t2_reg[0] <= 32'(x2_reg * HASH_MUL_X);
            t2_reg[1] <= 32'(y2_reg * HASH_MUL_Y);
            t2_reg[2] <= 32'(d1_reg.seed2 * HASH_MUL_S);
            t3_reg[0] <= 32'(xs_reg * HASH_MUL_X);
            t3_reg[1] <= 32'(ys_reg * HASH_MUL_Y);
            t3_reg[2] <= 32'(d1_reg.seeds * HASH_MUL_S);
        end
    end

    // stage 3: xor, fold and mix multiply
    kind_desc_t  d3_reg;
    logic [31:0] m1_reg, m2_reg, m3_reg;
    logic [31:0] v1, v2, v3;

    always_comb
    begin
        v1 = t1_reg[0] ^ t1_reg[1] ^ t1_reg[2];
        v2 = t2_reg[0] ^ t2_reg[1] ^ t2_reg[2];
        v3 = t3_reg[0] ^ t3_reg[1] ^ t3_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d3_reg <= d2_reg;
            m1_reg <= 32'((v1 ^ (v1 >> 13)) * HASH_MUL_M);
            m2_reg <= 32'((v2 ^ (v2 >> 13)) * HASH_MUL_M);
            m3_reg <= 32'((v3 ^ (v3 >> 13)) * HASH_MUL_M);
        end
    end

    // stage 4: final fold, amplitude scaling and selector compare
    logic [31:0] h1, h2, h3;
    logic [12:0] n1_reg;
    logic [11:0] n2_reg;
    logic        sel_reg;
    kind_desc_t  d4_reg;
    logic [36:0] p1;
    logic [35:0] p2;

    always_comb
    begin
        h1 = m1_reg ^ (m1_reg >> 16);
        h2 = m2_reg ^ (m2_reg >> 16);
        h3 = m3_reg ^ (m3_reg >> 16);
        p1 = 37'(h1) * 37'(d3_reg.amp1);
        p2 = 36'(h2) * 36'(d3_reg.amp2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d4_reg  <= d3_reg;
            n1_reg  <= p1[36:24];
            n2_reg  <= p2[35:24];
            sel_reg <= h3 > d3_reg.thr;
        end
    end

    // stage 5: base colour, noise sum, clamp and round
    logic signed [17:0] nz1, nz2, br, bg, bb;
    logic [7:0]         red_reg, green_reg, blue_reg;

    always_comb
    begin
        nz1 = $signed(18'(n1_reg)) - $signed({6'd0, d4_reg.off1, 8'd0});
        nz2 = $signed(18'(n2_reg)) - $signed({7'd0, d4_reg.off2, 8'd0});
        br  = $signed({2'd0, (sel_reg ? d4_reg.hit_r : d4_reg.miss_r), 8'd0});
        bg  = $signed({2'd0, (sel_reg ? d4_reg.hit_g : d4_reg.miss_g), 8'd0});
        bb  = $signed({2'd0, (sel_reg ? d4_reg.hit_b : d4_reg.miss_b), 8'd0});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= to_byte(18'(br + nz1 + nz2));
            green_reg <= to_byte(18'(bg + nz1 + nz2));
            blue_reg  <= to_byte(18'(bb + nz1));
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: bench/procedural_tile_pixel_generator_checker.sv
`timescale 1ns / 1ps
module procedural_tile_pixel_generator_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  logic       ready,
    input  logic [5:0] col,
    input  logic [5:0] line,
    input  logic [3:0] kind,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output int         fail_count,
    output int         pending_texels
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } texel_t;

    typedef struct {
        logic [31:0] seed_fine;
        int          amp_fine;
        int          off_fine;
        logic [31:0] seed_coarse;
        logic [31:0] scale_coarse;
        int          amp_coarse;
        int          off_coarse;
        logic [31:0] seed_sel;
        logic [31:0] scale_sel;
        logic [31:0] thresh;
        int          on_rgb[3];
        int          off_rgb[3];
    } terrain_t;

    texel_t    texel_q[$];
    terrain_t  terrain[10];

    initial
    begin
        terrain[0] = '{201, 25, 12, 0, 1, 0, 0, 202, 3, 32'd2576980377,
                       '{88, 95, 72}, '{115, 112, 98}};
        terrain[1] = '{211, 22, 11, 0, 1, 0, 0, 212, 4, 32'd2791728741,
                       '{45, 75, 40}, '{70, 90, 55}};
        terrain[2] = '{221, 12, 6, 0, 1, 0, 0, 222, 5, 32'd3951369911,
                       '{245, 243, 247}, '{228, 226, 230}};
        terrain[3] = '{231, 25, 12, 0, 1, 0, 0, 232, 2, 32'd2147483647,
                       '{130, 115, 78}, '{105, 120, 70}};
        terrain[4] = '{99, 30, 15, 0, 1, 0, 0, 100, 5, 32'd3006477106,
                       '{60, 110, 40}, '{75, 125, 50}};
        terrain[5] = '{241, 20, 10, 0, 1, 0, 0, 242, 3, 32'd2362232012,
                       '{68, 72, 45}, '{55, 80, 38}};
        terrain[6] = '{251, 22, 11, 252, 2, 10, 5, 0, 1, 32'hFFFFFFFF,
                       '{195, 175, 130}, '{195, 175, 130}};
        terrain[7] = '{261, 25, 12, 0, 1, 0, 0, 262, 4, 32'd3006477106,
                       '{140, 128, 75}, '{160, 145, 88}};
        terrain[8] = '{271, 28, 14, 0, 1, 0, 0, 272, 3, 32'd2362232012,
                       '{30, 105, 28}, '{55, 130, 45}};
        terrain[9] = '{281, 22, 11, 282, 4, 14, 7, 283, 2, 32'd2362232012,
                       '{158, 140, 104}, '{178, 158, 118}};
    end

    function automatic logic [31:0] mix_hash(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] s);
        logic [31:0] v;
        v = (x * 32'd374761393) ^ (y * 32'd668265263) ^ (s * 32'd1274126177);
        v = (v ^ (v >> 13)) * 32'd2246822519;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic longint scaled_noise(logic [31:0] h, int amp, int off);
        logic [63:0] p;
        p = ({32'd0, h} * 64'(amp)) >> 24;
        return longint'(p) - off * 256;
    endfunction

    function automatic logic [7:0] clamp_round(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255 * 256)
            return 8'd255;
        return 8'((v + 128) >> 8);
    endfunction

    function automatic texel_t texel_colour(logic [5:0] cx, logic [5:0] cy,
                                            logic [3:0] k);
        terrain_t t;
        longint   n1;
        longint   n2;
        logic     hit;
        int       c;
        longint   v;
        texel_t   res;
        logic [7:0] ch[3];
        t = terrain[(k >= 10) ? 0 : k];
        n1 = scaled_noise(mix_hash(cx, cy, t.seed_fine), t.amp_fine, t.off_fine);
        n2 = scaled_noise(mix_hash(cx * t.scale_coarse, cy * t.scale_coarse,
                                   t.seed_coarse), t.amp_coarse, t.off_coarse);
        hit = mix_hash(cx * t.scale_sel, cy * t.scale_sel, t.seed_sel) > t.thresh;
        for (c = 0; c < 3; c++)
        begin
            v = (hit ? t.on_rgb[c] : t.off_rgb[c]) * 256 + n1;
            if (c < 2)
                v += n2;
            ch[c] = clamp_round(v);
        end
        res.r = ch[0];
        res.g = ch[1];
        res.b = ch[2];
        return res;
    endfunction

    assign pending_texels = texel_q.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        texel_t e;
        if (rst_n)
        begin
            if (valid && ready)
                texel_q.push_back(texel_colour(col, line, kind));
            if (out_valid && out_ready)
            begin
                if (texel_q.size() == 0)
                begin
                    $error("unexpected item r=%0d g=%0d b=%0d", red, green, blue);
                    fail_count++;
                end
                else
                begin
                    e = texel_q.pop_front();
                    if (red !== e.r)
                    begin
                        $error("red: expected %0d, got %0d", e.r, red);
                        fail_count++;
                    end
                    if (green !== e.g)
                    begin
                        $error("green: expected %0d, got %0d", e.g, green);
                        fail_count++;
                    end
                    if (blue !== e.b)
                    begin
                        $error("blue: expected %0d, got %0d", e.b, blue);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/procedural_tile_pixel_generator_top_tb.sv
`timescale 1ns / 1ps
module procedural_tile_pixel_generator_top_tb;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       valid = 1'b0;
    logic       ready;
    logic [5:0] col = '0;
    logic [5:0] line = '0;
    logic [3:0] kind = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int         fail_count;
    int         pending_texels;

    // idle rates in percent, changed per phase
    int send_idle_pct = 6;
    int recv_idle_pct = 60;

    always #1 clk = ~clk;

    procedural_tile_pixel_generator_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .col       (col),
        .line      (line),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    procedural_tile_pixel_generator_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid          (valid),
        .ready          (ready),
        .col            (col),
        .line           (line),
        .kind           (kind),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .fail_count     (fail_count),
        .pending_texels (pending_texels)
    );

    // receiver side: random back-pressure, changed on the falling edge only
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one texel; a random idle gap may precede it, then hold until taken
    task automatic send_texel(logic [5:0] cx, logic [5:0] cy, logic [3:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid <= 1'b0;
            @(negedge clk);
        end
        valid <= 1'b1;
        col   <= cx;
        line  <= cy;
        kind  <= k;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // raster walk over random patches of random kind, a quarter of texels fully random
    task automatic random_texels(int count);
        int i;
        logic [3:0] k;
        logic [5:0] x0;
        logic [5:0] y0;
        k = 4'($urandom_range(15));
        x0 = 6'($urandom);
        y0 = 6'($urandom);
        for (i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                k = 4'($urandom_range(15));
                x0 = 6'($urandom);
                y0 = 6'($urandom);
            end
            if ($urandom_range(3) == 0)
                send_texel(6'($urandom), 6'($urandom), 4'($urandom));
            else
                send_texel(x0 + 6'(i % 4), y0 + 6'((i % 16) / 4), k);
        end
    endtask

    initial
    begin
        int i;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every kind including the fall-back ones at the tile corners, then two interior texels
        for (i = 0; i < 16; i++)
            send_texel((i % 2) ? 6'd63 : 6'd0, (i % 4 >= 2) ? 6'd63 : 6'd0, 4'(i));
        send_texel(6'd63, 6'd63, 4'd15);
        send_texel(6'd0, 6'd0, 4'd9);
        send_texel(6'd21, 6'd42, 4'd6);
        send_texel(6'd42, 6'd21, 4'd2);

        // phase one: sender rarely idle, receiver often stalls
        random_texels(200);
        send_idle_pct = 60;
        recv_idle_pct = 6;
        random_texels(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_texels(200);
        valid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (pending_texels != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("procedural_tile_pixel_generator_top_tb: done, clean");
        else
            $display("procedural_tile_pixel_generator_top_tb: done, errors");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial
    begin
        #400000;
        $display("procedural_tile_pixel_generator_top_tb: done, errors");
        $finish;
    end

endmodule
